@@ src/assert_macros.svh @@
// shared assertion macros for the route lookup block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ src/lprl_pkg.sv @@
// ----------------------------------------------------------------------------
// lprl_pkg
// shared constants and types of the longest-prefix route lookup block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lprl_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int NUM_PORTS   = 4;
	localparam int ADDR_W      = 32;
	localparam int PORT_W      = 2;
	localparam int INDEX_W     = 4;
	localparam int TBL_AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int JOBQ_DEPTH  = 2;
	localparam int JOBQ_AW     = 1;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		OP_STORE,
		OP_INVAL,
		OP_LOOKUP
	} op_t;

	typedef struct packed {
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
	} route_entry_t;

	typedef struct packed {
		op_t               op;
		logic [TBL_AW-1:0] slot;
		route_entry_t      entry;
		logic [ADDR_W-1:0] addr;
	} job_t;

	// head of the job queue as seen by the back end
	typedef struct packed {
		logic avail;
		job_t job;
	} jobq_head_t;

endpackage

@@ src/lprl_ram.sv @@
// ----------------------------------------------------------------------------
// lprl_ram
// generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lprl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/lprl_front.sv @@
// ----------------------------------------------------------------------------
// lprl_front
// accepts input items, sorts them into store, invalidate and lookup jobs,
// drops writes that cannot take effect, and queues the rest for the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lprl_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            cmd,
	input  logic [lprl_pkg::INDEX_W-1:0]    entry_index,
	input  logic                            entry_valid,
	input  logic [lprl_pkg::ADDR_W-1:0]     entry_dest,
	input  logic [lprl_pkg::ADDR_W-1:0]     entry_mask,
	input  logic [lprl_pkg::ADDR_W-1:0]     entry_gateway,
	input  logic [lprl_pkg::PORT_W-1:0]     entry_port,
	input  logic [lprl_pkg::ADDR_W-1:0]     lookup_addr,
	output lprl_pkg::jobq_head_t            jq,
	input  logic                            jq_pop
);

	lprl_pkg::job_t                  job_in;
	logic                            keep;
	logic                            idx_ok;
	logic                            port_ok;
	logic                            enq;
	logic                            deq;
	lprl_pkg::job_t                  q_mem [lprl_pkg::JOBQ_DEPTH];
	logic [lprl_pkg::JOBQ_AW-1:0]    wr_ptr_q;
	logic [lprl_pkg::JOBQ_AW-1:0]    rd_ptr_q;
	logic [lprl_pkg::JOBQ_AW:0]      cnt_q;

	always_comb begin
		idx_ok  = 32'(entry_index) < 32'(lprl_pkg::TABLE_DEPTH);
		port_ok = 32'(entry_port) < 32'(lprl_pkg::NUM_PORTS);
		job_in.slot          = lprl_pkg::TBL_AW'(entry_index);
		job_in.entry.dest    = entry_dest;
		job_in.entry.mask    = entry_mask;
		job_in.entry.gateway = entry_gateway;
		job_in.entry.port    = entry_port;
		job_in.addr          = lookup_addr;
		if (cmd == lprl_pkg::CMD_LOOKUP) begin
			job_in.op = lprl_pkg::OP_LOOKUP;
			keep      = 1'b1;
		end else if (entry_valid) begin
			job_in.op = lprl_pkg::OP_STORE;
			keep      = idx_ok && port_ok;
		end else begin
			job_in.op = lprl_pkg::OP_INVAL;
			keep      = idx_ok;
		end
	end

	assign full = (cnt_q == (lprl_pkg::JOBQ_AW + 1)'(lprl_pkg::JOBQ_DEPTH));
	// a write that would be ignored is still a transfer, it just never queues
	assign enq  = push && !full && keep;
	assign deq  = jq_pop && (cnt_q != '0);

	assign jq.avail = (cnt_q != '0);
	assign jq.job   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= (lprl_pkg::JOBQ_AW + 1)'(lprl_pkg::JOBQ_DEPTH))
	`ASSERT_NXT(a_cnt_grow, clk, arst_n, enq && !deq, cnt_q == $past(cnt_q) + 1'b1)

endmodule

@@ src/lprl_back.sv @@
// ----------------------------------------------------------------------------
// lprl_back
// carries out queued jobs: table writes, lookups by scanning
// the entry RAM one slot per cycle, result held in an output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lprl_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lprl_pkg::jobq_head_t                jq,
	output logic                                jq_pop,
	output logic                                ram_we,
	output logic [lprl_pkg::TBL_AW-1:0]         ram_waddr,
	output lprl_pkg::route_entry_t              ram_wdata,
	output logic [lprl_pkg::TBL_AW-1:0]         ram_raddr,
	input  lprl_pkg::route_entry_t              ram_rdata,
	output logic                                empty,
	input  logic                                pop,
	output logic                                found,
	output logic [lprl_pkg::PORT_W-1:0]         out_port,
	output logic [lprl_pkg::ADDR_W-1:0]         next_hop
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [lprl_pkg::TABLE_DEPTH-1:0]  valid_q;
	logic [lprl_pkg::TBL_AW-1:0]       scan_addr_q;
	logic [lprl_pkg::ADDR_W-1:0]       addr_q;
	logic                              hit_q;
	logic [lprl_pkg::ADDR_W-1:0]       best_mask_q;
	logic [lprl_pkg::ADDR_W-1:0]       best_gw_q;
	logic [lprl_pkg::PORT_W-1:0]       best_port_q;
	logic                              out_valid_q;
	logic                              found_q;
	logic [lprl_pkg::PORT_W-1:0]       out_port_q;
	logic [lprl_pkg::ADDR_W-1:0]       next_hop_q;
	logic                              last;
	logic                              hit_now;
	logic                              take;
	logic                              out_free;

	assign jq_pop    = (state_q == ST_IDLE) && jq.avail;
	assign ram_we    = jq_pop && (jq.job.op == lprl_pkg::OP_STORE);
	assign ram_waddr = jq.job.slot;
	assign ram_wdata = jq.job.entry;
	// idle presents slot 0 so a starting lookup has its data in its first scan cycle
	assign ram_raddr = (state_q == ST_SCAN) ? lprl_pkg::TBL_AW'(scan_addr_q + 1'b1) : '0;

	assign last     = (scan_addr_q == lprl_pkg::TBL_AW'(lprl_pkg::TABLE_DEPTH - 1));
	assign hit_now  = valid_q[scan_addr_q]
		&& ((addr_q & ram_rdata.mask) == (ram_rdata.dest & ram_rdata.mask));
	// >= lets the later slot win on equal masks
	assign take     = hit_now && (!hit_q || (ram_rdata.mask >= best_mask_q));
	assign out_free = !out_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			scan_addr_q <= '0;
			addr_q      <= '0;
			hit_q       <= 1'b0;
			best_mask_q <= '0;
			best_gw_q   <= '0;
			best_port_q <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			out_port_q  <= '0;
			next_hop_q  <= '0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (jq.avail) begin
						unique case (jq.job.op)
							lprl_pkg::OP_STORE: begin
								valid_q[jq.job.slot] <= 1'b1;
							end
							lprl_pkg::OP_INVAL: begin
								valid_q[jq.job.slot] <= 1'b0;
							end
							lprl_pkg::OP_LOOKUP: begin
								addr_q      <= jq.job.addr;
								scan_addr_q <= '0;
								hit_q       <= 1'b0;
								best_mask_q <= '0;
								state_q     <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (take) begin
						hit_q       <= 1'b1;
						best_mask_q <= ram_rdata.mask;
						best_gw_q   <= ram_rdata.gateway;
						best_port_q <= ram_rdata.port;
					end
					scan_addr_q <= scan_addr_q + 1'b1;
					if (last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						found_q     <= hit_q;
						out_port_q  <= hit_q ? best_port_q : '0;
						if (!hit_q) begin
							next_hop_q <= '0;
						end else if (best_gw_q != '0) begin
							next_hop_q <= best_gw_q;
						end else begin
							next_hop_q <= addr_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty    = !out_valid_q;
	assign found    = found_q;
	assign out_port = out_port_q;
	assign next_hop = next_hop_q;

	`ASSERT_NXT(a_scan_runs, clk, arst_n, (state_q == ST_SCAN) && !last, state_q == ST_SCAN)
	`ASSERT_NXT(a_result_held, clk, arst_n, out_valid_q && !pop, out_valid_q && $stable(next_hop_q))

endmodule

@@ src/longest_prefix_route_lookup.sv @@
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// IPv4 routing table with longest-prefix match over a fixed number of slots
//
// Input side is a queue: an item transfers when push is high and full low.
// cmd selects a slot write (store or invalidate, no result) or a lookup
// (one result of found, out_port and next_hop). Output side is a queue:
// the oldest result sits on the ports while empty is low and transfers
// when pop is high.
// With the back end idle, an item leaves the two-entry job queue in the cycle
// after its transfer, and a write takes effect as it leaves. A lookup then
// scans the entry RAM one slot per cycle through its single read port over
// all TABLE_DEPTH slots and then registers its result; the back end takes
// no other job from the queue until that result is registered, so lookups
// do not overlap.
// Reset clears all valid bits and both queues; no clearing pass is needed.
// If the receiver stalls, the finished result holds; the next lookup still
// scans and then waits for the register to free, and the job queue keeps
// taking items until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module longest_prefix_route_lookup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic                            cmd,
	input  logic [lprl_pkg::INDEX_W-1:0]    entry_index,
	input  logic                            entry_valid,
	input  logic [lprl_pkg::ADDR_W-1:0]     entry_dest,
	input  logic [lprl_pkg::ADDR_W-1:0]     entry_mask,
	input  logic [lprl_pkg::ADDR_W-1:0]     entry_gateway,
	input  logic [lprl_pkg::PORT_W-1:0]     entry_port,
	input  logic [lprl_pkg::ADDR_W-1:0]     lookup_addr,
	output logic                            empty,
	input  logic                            pop,
	output logic                            found,
	output logic [lprl_pkg::PORT_W-1:0]     out_port,
	output logic [lprl_pkg::ADDR_W-1:0]     next_hop
);

	lprl_pkg::jobq_head_t           jq;
	logic                           jq_pop;
	logic                           ram_we;
	logic [lprl_pkg::TBL_AW-1:0]    ram_waddr;
	lprl_pkg::route_entry_t         ram_wdata;
	logic [lprl_pkg::TBL_AW-1:0]    ram_raddr;
	lprl_pkg::route_entry_t         ram_rdata;

	lprl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.entry_index   (entry_index),
		.entry_valid   (entry_valid),
		.entry_dest    (entry_dest),
		.entry_mask    (entry_mask),
		.entry_gateway (entry_gateway),
		.entry_port    (entry_port),
		.lookup_addr   (lookup_addr),
		.jq            (jq),
		.jq_pop        (jq_pop)
	);

	lprl_ram #(
		.WIDTH ($bits(lprl_pkg::route_entry_t)),
		.DEPTH (lprl_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lprl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.jq        (jq),
		.jq_pop    (jq_pop),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.empty     (empty),
		.pop       (pop),
		.found     (found),
		.out_port  (out_port),
		.next_hop  (next_hop)
	);

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the longest-prefix route lookup block: writes and
// lookups go in through the push/full queue while a shadow routing table
// predicts each lookup result; results come out through empty/pop with
// random stalls on both sides (none in the back-to-back run) and are checked in order, field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic                         cmd;
		logic [lprl_pkg::INDEX_W-1:0] index;
		logic                         valid;
		logic [lprl_pkg::ADDR_W-1:0]  dest;
		logic [lprl_pkg::ADDR_W-1:0]  mask;
		logic [lprl_pkg::ADDR_W-1:0]  gateway;
		logic [lprl_pkg::PORT_W-1:0]  port;
		logic [lprl_pkg::ADDR_W-1:0]  addr;
	} route_item_t;

	typedef struct packed {
		logic                        found;
		logic [lprl_pkg::PORT_W-1:0] port;
		logic [lprl_pkg::ADDR_W-1:0] hop;
	} route_result_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         push = 1'b0;
	logic                         full;
	logic                         cmd = lprl_pkg::CMD_WRITE;
	logic [lprl_pkg::INDEX_W-1:0] entry_index = '0;
	logic                         entry_valid = 1'b0;
	logic [lprl_pkg::ADDR_W-1:0]  entry_dest = '0;
	logic [lprl_pkg::ADDR_W-1:0]  entry_mask = '0;
	logic [lprl_pkg::ADDR_W-1:0]  entry_gateway = '0;
	logic [lprl_pkg::PORT_W-1:0]  entry_port = '0;
	logic [lprl_pkg::ADDR_W-1:0]  lookup_addr = '0;
	logic                         empty;
	logic                         pop = 1'b0;
	logic                         found;
	logic [lprl_pkg::PORT_W-1:0]  out_port;
	logic [lprl_pkg::ADDR_W-1:0]  next_hop;

	// shadow routing table
	logic                        shadow_valid [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::ADDR_W-1:0] shadow_dest [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::ADDR_W-1:0] shadow_mask [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::ADDR_W-1:0] shadow_gateway [lprl_pkg::TABLE_DEPTH];
	logic [lprl_pkg::PORT_W-1:0] shadow_port [lprl_pkg::TABLE_DEPTH];

	route_result_t pending_routes[$];
	int unsigned   mismatches = 0;
	int unsigned   tx_idle_pct = 38;
	int unsigned   rx_idle_pct = 38;
	logic [lprl_pkg::ADDR_W-1:0] net_pool [4];

	longest_prefix_route_lookup dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.cmd           (cmd),
		.entry_index   (entry_index),
		.entry_valid   (entry_valid),
		.entry_dest    (entry_dest),
		.entry_mask    (entry_mask),
		.entry_gateway (entry_gateway),
		.entry_port    (entry_port),
		.lookup_addr   (lookup_addr),
		.empty         (empty),
		.pop           (pop),
		.found         (found),
		.out_port      (out_port),
		.next_hop      (next_hop)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("longest_prefix_route_lookup test failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < lprl_pkg::TABLE_DEPTH; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_dest[i] = '0;
			shadow_mask[i] = '0;
			shadow_gateway[i] = '0;
			shadow_port[i] = '0;
		end
	end

	// update the shadow table, or queue the expected lookup result
	task automatic route_table_apply(input route_item_t it);
		logic                        hit;
		logic [lprl_pkg::ADDR_W-1:0] best_mask;
		int                          best;
		route_result_t               res;
		hit = 1'b0;
		best_mask = '0;
		best = 0;
		if (it.cmd == lprl_pkg::CMD_WRITE) begin
			if (int'(it.index) >= lprl_pkg::TABLE_DEPTH)
				return;
			if (!it.valid) begin
				// only the valid bit goes away
				shadow_valid[it.index] = 1'b0;
				return;
			end
			if (int'(it.port) >= lprl_pkg::NUM_PORTS)
				return;
			shadow_valid[it.index] = 1'b1;
			shadow_dest[it.index] = it.dest;
			shadow_mask[it.index] = it.mask;
			shadow_gateway[it.index] = it.gateway;
			shadow_port[it.index] = it.port;
		end else begin
			for (int i = 0; i < lprl_pkg::TABLE_DEPTH; i++) begin
				if (shadow_valid[i] &&
				    ((it.addr & shadow_mask[i]) == (shadow_dest[i] & shadow_mask[i])) &&
				    (!hit || shadow_mask[i] >= best_mask)) begin
					hit = 1'b1;
					best_mask = shadow_mask[i];
					best = i;
				end
			end
			if (hit) begin
				res.found = 1'b1;
				res.port = shadow_port[best];
				res.hop = (shadow_gateway[best] != '0) ? shadow_gateway[best] : it.addr;
			end else begin
				res = '0;
			end
			pending_routes.push_back(res);
		end
	endtask

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_item(input route_item_t it);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		cmd <= it.cmd;
		entry_index <= it.index;
		entry_valid <= it.valid;
		entry_dest <= it.dest;
		entry_mask <= it.mask;
		entry_gateway <= it.gateway;
		entry_port <= it.port;
		lookup_addr <= it.addr;
		do
			@(posedge clk);
		while (full);
		route_table_apply(it);
		@(negedge clk);
	endtask

	task automatic write_route(input int idx, input logic valid,
	                           input logic [lprl_pkg::ADDR_W-1:0] dest,
	                           input logic [lprl_pkg::ADDR_W-1:0] mask,
	                           input logic [lprl_pkg::ADDR_W-1:0] gw,
	                           input int port);
		route_item_t it;
		it.cmd = lprl_pkg::CMD_WRITE;
		it.index = idx[lprl_pkg::INDEX_W-1:0];
		it.valid = valid;
		it.dest = dest;
		it.mask = mask;
		it.gateway = gw;
		it.port = port[lprl_pkg::PORT_W-1:0];
		it.addr = $urandom;
		send_item(it);
	endtask

	task automatic lookup_route(input logic [lprl_pkg::ADDR_W-1:0] addr);
		route_item_t it;
		// entry fields carry junk, a lookup must ignore them
		it.cmd = lprl_pkg::CMD_LOOKUP;
		it.index = lprl_pkg::INDEX_W'($urandom);
		it.valid = 1'($urandom);
		it.dest = $urandom;
		it.mask = $urandom;
		it.gateway = $urandom;
		it.port = lprl_pkg::PORT_W'($urandom);
		it.addr = addr;
		send_item(it);
	endtask

	function automatic logic [lprl_pkg::ADDR_W-1:0] prefix_mask(input int len);
		return (len == 0) ? '0
		                  : ({lprl_pkg::ADDR_W{1'b1}} << (lprl_pkg::ADDR_W - len));
	endfunction

	always @(negedge clk)
		pop <= ($urandom_range(0, 99) >= rx_idle_pct);

	always @(posedge clk) begin
		route_result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_routes.size() == 0) begin
				$display("%0t: unexpected result found %0d out_port %0d next_hop %h",
				         $time, found, out_port, next_hop);
				mismatches++;
			end else begin
				want = pending_routes.pop_front();
				if (found !== want.found) begin
					$display("%0t: found expected %0d actual %0d", $time, want.found, found);
					mismatches++;
				end
				if (out_port !== want.port) begin
					$display("%0t: out_port expected %0d actual %0d", $time, want.port,
					         out_port);
					mismatches++;
				end
				if (next_hop !== want.hop) begin
					$display("%0t: next_hop expected %h actual %h", $time, want.hop,
					         next_hop);
					mismatches++;
				end
			end
		end
	end

	task automatic test_directed_routes();
		// empty table, address extremes
		lookup_route(32'h0000_0000);
		lookup_route(32'hffff_ffff);
		// default route and host route at the two ends of the table
		write_route(0, 1'b1, $urandom, 32'h0000_0000, 32'hc0a8_0001, 1);
		write_route(lprl_pkg::TABLE_DEPTH - 1, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 3);
		lookup_route(32'hffff_ffff);
		lookup_route(32'h0000_0000);
		// equal masks, the higher slot wins; dest bits outside the mask ignored
		write_route(5, 1'b1, 32'h0a00_0000, 32'hff00_0000, 32'h0a00_00fe, 2);
		write_route(9, 1'b1, 32'h0a12_3456, 32'hff00_0000, 32'hffff_ffff, 0);
		lookup_route(32'h0a0a_0a0a);
		// longer prefix at a lower slot beats both
		write_route(3, 1'b1, 32'h0a0a_0000, 32'hffff_0000, 32'h0, 3);
		lookup_route(32'h0a0a_0a0a);
		// invalidate with junk fields
		write_route(9, 1'b0, $urandom, $urandom, $urandom, 3);
		lookup_route(32'h0a0b_0c0d);
		write_route(0, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0);
		lookup_route(32'h0b00_0000);
		// masks compare as unsigned host-order numbers
		write_route(9, 1'b1, 32'h0a00_0000, 32'h8000_0000, 32'h0000_0001, 1);
		lookup_route(32'h0a0b_0c0d);
		lookup_route(32'h7fff_ffff);
		lookup_route(32'h0a0a_0a0a);
		write_route(lprl_pkg::TABLE_DEPTH - 1, 1'b0, 32'h0, 32'h0, 32'h0, 0);
		lookup_route(32'hffff_ffff);
	endtask

	task automatic test_prefix_traffic(input int unsigned n_items);
		int unsigned roll;
		int          slot;
		int          len;
		for (int k = 0; k < 4; k++)
			net_pool[k] = $urandom;
		for (int unsigned n = 0; n < n_items; n++) begin
			roll = $urandom_range(0, 99);
			slot = $urandom_range(0, lprl_pkg::TABLE_DEPTH - 1);
			if (roll < 30) begin
				// nested prefixes of a few shared networks
				len = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? 0 : 32)
				                                  : $urandom_range(1, 31);
				write_route(slot, 1'b1, net_pool[$urandom_range(0, 3)] ^ ($urandom & ~prefix_mask(len)),
				            prefix_mask(len), ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom,
				            $urandom_range(0, 3));
			end else if (roll < 36) begin
				write_route(slot, 1'b0, $urandom, $urandom, $urandom, $urandom_range(0, 3));
			end else if (roll < 42) begin
				// arbitrary non-prefix masks
				write_route(slot, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
				            $urandom_range(0, 3));
			end else if (roll < 82) begin
				lookup_route((shadow_dest[slot] & shadow_mask[slot]) |
				             ($urandom & ~shadow_mask[slot]));
			end else if (roll < 92) begin
				lookup_route(net_pool[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(0, 31)));
			end else begin
				lookup_route($urandom);
			end
		end
	endtask

	task automatic test_back_to_back(input int unsigned n_items);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_prefix_traffic(n_items);
		tx_idle_pct = 38;
		rx_idle_pct = 38;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_routes();
		test_prefix_traffic(750);
		test_back_to_back(250);
		test_prefix_traffic(750);
		push <= 1'b0;
		while (pending_routes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && pending_routes.size() == 0)
			$display("longest_prefix_route_lookup test passed");
		else
			$display("longest_prefix_route_lookup test failed");
		$finish;
	end

endmodule
